[rtl/ntr_pkg.sv]
// ----------------------------------------------------------------------------
// ntr_pkg
// Shared sizes, codes and types of the name-to-task registry.
// ----------------------------------------------------------------------------
package ntr_pkg;

    // Table geometry
    localparam int ENTRIES      = 1024;
    localparam int KEY_BITS     = 64;
    localparam int TASK_ID_BITS = 16;

    // Fixed field widths at the ports
    localparam int KEY_FIELD_BITS  = 64;
    localparam int TASK_FIELD_BITS = 16;

    // Effective owner width: the task field is narrowed to both limits
    localparam int TASK_W = (TASK_ID_BITS < TASK_FIELD_BITS) ? TASK_ID_BITS
                                                             : TASK_FIELD_BITS;

    localparam int ADDR_BITS = $clog2(ENTRIES);
    localparam int CNT_BITS  = ADDR_BITS + 1;

    // Request codes
    typedef enum logic [1:0] {
        ACT_FIND     = 2'd0,
        ACT_REGISTER = 2'd1,
        ACT_TASK_END = 2'd2
    } action_t;

    // Controller states
    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_SCAN,
        ST_FINISH
    } state_t;

    // One table entry as stored in memory
    typedef struct packed {
        logic              valid;
        logic [TASK_W-1:0] owner;
        logic [KEY_BITS-1:0] key;
    } entry_t;

    // Memory access bundle from the controller
    typedef struct packed {
        logic                 re;
        logic [ADDR_BITS-1:0] raddr;
        logic                 we;
        logic [ADDR_BITS-1:0] waddr;
        entry_t               wdata;
    } mem_req_t;

endpackage

[rtl/name_to_task_registry.sv]
// ----------------------------------------------------------------------------
// name_to_task_registry
// Maps a service name key to the id of the task that owns it.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid / in_stall) carries action, name_key and
//   requester_task. Action find looks up the key, register stores it in the
//   lowest free entry unless the key is held or the table is full, task
//   ended frees every entry owned by that task.
//   Output channel (out_valid / out_stall) returns ok and owner_task, one
//   result per request.
//   Each request reads every entry once through the single memory read
//   port, one entry per cycle, and a new request is taken the cycle after
//   the previous result is loaded.
//   After reset a clearing pass writes every entry invalid; in_stall stays
//   high while it runs.
//   A result held under out_stall stays put; the block still accepts and
//   scans the next request, and waits only to load that next result.
// ----------------------------------------------------------------------------
module name_to_task_registry
    import ntr_pkg::*;
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    output logic                       in_stall,
    input  logic [1:0]                 action,
    input  logic [KEY_FIELD_BITS-1:0]  name_key,
    input  logic [TASK_FIELD_BITS-1:0] requester_task,
    output logic                       out_valid,
    input  logic                       out_stall,
    output logic                       ok,
    output logic [TASK_FIELD_BITS-1:0] owner_task
);

    localparam logic [CNT_BITS-1:0] CNT_END = CNT_BITS'(ENTRIES);

    state_t state_reg, state_next;
    logic [CNT_BITS-1:0]  cnt_reg, cnt_next;
    logic                 pend_reg, pend_next;
    logic [ADDR_BITS-1:0] idx_reg, idx_next;
    action_t              act_reg, act_next;
    logic [KEY_BITS-1:0]  key_reg, key_next;
    logic [TASK_W-1:0]    task_reg, task_next;
    logic                 found_reg, found_next;
    logic [TASK_W-1:0]    hit_owner_reg, hit_owner_next;
    logic                 free_ok_reg, free_ok_next;
    logic [ADDR_BITS-1:0] free_slot_reg, free_slot_next;
    logic                 out_valid_reg, out_valid_next;
    logic                 ok_reg, ok_next;
    logic [TASK_W-1:0]    owner_reg, owner_next;

    mem_req_t mem_req;
    entry_t   rd_entry;
    logic     out_load;

    // Entry store
    ntr_ram u_ram (
        .clk   (clk),
        .req   (mem_req),
        .rdata (rd_entry)
    );

    // Result can be loaded once the output register is free or draining
    assign out_load = (state_reg == ST_FINISH) && (!out_valid_reg || !out_stall);

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_CLEAR:
            begin
                if (cnt_reg == CNT_END)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (cnt_reg == CNT_END && !pend_reg)
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                if (out_load)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Datapath, memory accesses and result
    always_comb
    begin
        cnt_next       = cnt_reg;
        pend_next      = 1'b0;
        idx_next       = idx_reg;
        act_next       = act_reg;
        key_next       = key_reg;
        task_next      = task_reg;
        found_next     = found_reg;
        hit_owner_next = hit_owner_reg;
        free_ok_next   = free_ok_reg;
        free_slot_next = free_slot_reg;
        out_valid_next = out_valid_reg;
        ok_next        = ok_reg;
        owner_next     = owner_reg;
        mem_req        = '0;

        // Output register drains on acceptance
        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            ST_CLEAR:
            begin
                // Sweep every entry to invalid
                if (cnt_reg != CNT_END)
                begin
                    mem_req.we    = 1'b1;
                    mem_req.waddr = cnt_reg[ADDR_BITS-1:0];
                    cnt_next      = cnt_reg + 1'b1;
                end
            end
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    act_next     = action_t'(action);
                    key_next     = name_key[KEY_BITS-1:0];
                    task_next    = requester_task[TASK_W-1:0];
                    cnt_next     = '0;
                    found_next   = 1'b0;
                    free_ok_next = 1'b0;
                end
            end
            ST_SCAN:
            begin
                // Issue the next read
                if (cnt_reg != CNT_END)
                begin
                    mem_req.re    = 1'b1;
                    mem_req.raddr = cnt_reg[ADDR_BITS-1:0];
                    idx_next      = cnt_reg[ADDR_BITS-1:0];
                    pend_next     = 1'b1;
                    cnt_next      = cnt_reg + 1'b1;
                end
                // Examine the entry read last cycle
                if (pend_reg)
                begin
                    case (act_reg)
                        ACT_FIND, ACT_REGISTER:
                        begin
                            if (rd_entry.valid)
                            begin
                                if (!found_reg && rd_entry.key == key_reg)
                                begin
                                    found_next     = 1'b1;
                                    hit_owner_next = rd_entry.owner;
                                end
                            end
                            else if (!free_ok_reg)
                            begin
                                free_ok_next   = 1'b1;
                                free_slot_next = idx_reg;
                            end
                        end
                        ACT_TASK_END:
                        begin
                            // Free entries of the ended task in place
                            if (rd_entry.valid && rd_entry.owner == task_reg)
                            begin
                                mem_req.we    = 1'b1;
                                mem_req.waddr = idx_reg;
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            ST_FINISH:
            begin
                if (out_load)
                begin
                    out_valid_next = 1'b1;
                    ok_next        = 1'b0;
                    owner_next     = '0;
                    case (act_reg)
                        ACT_FIND:
                        begin
                            if (found_reg)
                            begin
                                ok_next    = 1'b1;
                                owner_next = hit_owner_reg;
                            end
                        end
                        ACT_REGISTER:
                        begin
                            if (!found_reg && free_ok_reg)
                            begin
                                mem_req.we          = 1'b1;
                                mem_req.waddr       = free_slot_reg;
                                mem_req.wdata.valid = 1'b1;
                                mem_req.wdata.owner = task_reg;
                                mem_req.wdata.key   = key_reg;
                                ok_next             = 1'b1;
                                owner_next          = task_reg;
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            default:
            begin
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            cnt_reg       <= '0;
            pend_reg      <= 1'b0;
            found_reg     <= 1'b0;
            free_ok_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            pend_reg      <= pend_next;
            found_reg     <= found_next;
            free_ok_reg   <= free_ok_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        idx_reg       <= idx_next;
        act_reg       <= act_next;
        key_reg       <= key_next;
        task_reg      <= task_next;
        hit_owner_reg <= hit_owner_next;
        free_slot_reg <= free_slot_next;
        ok_reg        <= ok_next;
        owner_reg     <= owner_next;
    end

    // Ports
    assign in_stall   = (state_reg != ST_IDLE);
    assign out_valid  = out_valid_reg;
    assign ok         = ok_reg;
    assign owner_task = TASK_FIELD_BITS'(owner_reg);

    // Checks
    a_no_write_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_IDLE) |-> !mem_req.we)
        else $error("memory written while idle");

    a_scan_write_in_place: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SCAN && mem_req.we) |->
            (act_reg == ACT_TASK_END && pend_reg && mem_req.waddr == idx_reg))
        else $error("scan write not at the entry just read");

    a_pend_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
        pend_reg |-> (state_reg == ST_SCAN))
        else $error("read data pending outside a scan");

    a_result_from_finish: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == ST_FINISH))
        else $error("result loaded outside finish");

    a_ok_needs_owner_path: assert property (@(posedge clk) disable iff (!rst_n)
        (out_load && act_reg == ACT_TASK_END) |=> !ok_reg)
        else $error("task ended reported ok");

endmodule

[rtl/ntr_ram.sv]
// ----------------------------------------------------------------------------
// ntr_ram
// Entry store: one write port, one read port, read data registered.
// ----------------------------------------------------------------------------
module ntr_ram
    import ntr_pkg::*;
(
    input  logic     clk,
    input  mem_req_t req,
    output entry_t   rdata
);

    entry_t mem [ENTRIES];
    entry_t rdata_reg;

    // Write port
    always_ff @(posedge clk)
    begin
        if (req.we)
        begin
            mem[req.waddr] <= req.wdata;
        end
    end

    // Read port, registered
    always_ff @(posedge clk)
    begin
        if (req.re)
        begin
            rdata_reg <= mem[req.raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

[dv/tb_name_to_task_registry.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_name_to_task_registry
// Self-checking bench for the name-to-task registry.
// Requests go in one at a time through the valid/stall channel. A shadow copy
// of the table predicts each reply when its request is taken, and every reply
// seen on the output channel is compared with the oldest prediction. Directed
// corner cases come first, then random register, find, task-ended and unused
// requests under varying back-pressure, then a table fill to full and a last mix.
// ----------------------------------------------------------------------------
module tb_name_to_task_registry;
    import ntr_pkg::*;

    // Code that the action enum leaves unused
    localparam logic [1:0] ACT_UNUSED = 2'd3;

    localparam int WATCHDOG_LIMIT = 12000;
    localparam int DRAIN_CYCLES   = ENTRIES + 64;
    localparam int KEY_POOL_SIZE  = 16;
    localparam int ID_POOL_SIZE   = 6;
    localparam int FILL_OWNERS    = 4;

    localparam logic [KEY_FIELD_BITS-1:0]  KEY_ONES = '1;
    localparam logic [TASK_FIELD_BITS-1:0] ID_ONES  = '1;

    typedef struct packed {
        logic                       ok;
        logic [TASK_FIELD_BITS-1:0] owner;
    } reply_t;

    logic                       clk;
    logic                       rst_n;
    logic                       in_valid;
    logic                       in_stall;
    logic [1:0]                 action;
    logic [KEY_FIELD_BITS-1:0]  name_key;
    logic [TASK_FIELD_BITS-1:0] requester_task;
    logic                       out_valid;
    logic                       out_stall;
    logic                       ok;
    logic [TASK_FIELD_BITS-1:0] owner_task;

    // Shadow table
    bit                  slot_valid [ENTRIES];
    logic [KEY_BITS-1:0] slot_key   [ENTRIES];
    logic [TASK_W-1:0]   slot_owner [ENTRIES];

    reply_t expected_replies[$];
    reply_t last_predicted;
    reply_t oldest_reply;
    int     mismatch_count;
    int     tx_idle_pct;
    int     rx_idle_pct;

    name_to_task_registry DUT (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .action         (action),
        .name_key       (name_key),
        .requester_task (requester_task),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .ok             (ok),
        .owner_task     (owner_task)
    );

    // Clock
    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // Registry behavior: scan for a key match and the lowest free slot, or free an ended task's slots
    function automatic reply_t predict_registry(logic [1:0] act,
                                                logic [KEY_FIELD_BITS-1:0] key_in,
                                                logic [TASK_FIELD_BITS-1:0] id_in);
        logic [KEY_BITS-1:0] key_m;
        logic [TASK_W-1:0]   id_m;
        reply_t              res;
        int                  hit;
        int                  free_idx;
        key_m    = key_in[KEY_BITS-1:0];
        id_m     = id_in[TASK_W-1:0];
        res      = '0;
        hit      = -1;
        free_idx = -1;
        if (act == ACT_FIND || act == ACT_REGISTER)
        begin
            for (int i = 0; i < ENTRIES; i++)
            begin
                if (slot_valid[i])
                begin
                    if (hit < 0 && slot_key[i] == key_m)
                        hit = i;
                end
                else if (free_idx < 0)
                    free_idx = i;
            end
            if (act == ACT_FIND)
            begin
                if (hit >= 0)
                begin
                    res.ok    = 1'b1;
                    res.owner = TASK_FIELD_BITS'(slot_owner[hit]);
                end
            end
            else if (hit < 0 && free_idx >= 0)
            begin
                slot_valid[free_idx] = 1'b1;
                slot_key[free_idx]   = key_m;
                slot_owner[free_idx] = id_m;
                res.ok    = 1'b1;
                res.owner = TASK_FIELD_BITS'(id_m);
            end
        end
        else if (act == ACT_TASK_END)
        begin
            // free everything the ended task owns
            for (int i = 0; i < ENTRIES; i++)
                if (slot_valid[i] && slot_owner[i] == id_m)
                    slot_valid[i] = 1'b0;
        end
        return res;
    endfunction

    task automatic set_idle(int tx_pct, int rx_pct);
        tx_idle_pct = tx_pct;
        rx_idle_pct = rx_pct;
    endtask

    // Drive one request, wait for it to be taken, then predict its reply
    task automatic send_request(logic [1:0] act, logic [KEY_FIELD_BITS-1:0] key_in,
                                logic [TASK_FIELD_BITS-1:0] id_in);
        @(negedge clk);
        while ($urandom_range(99) < tx_idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid       <= 1'b1;
        action         <= act;
        name_key       <= key_in;
        requester_task <= id_in;
        @(posedge clk);
        while (in_stall !== 1'b0)
            @(posedge clk);
        last_predicted = predict_registry(act, key_in, id_in);
        expected_replies.push_back(last_predicted);
    endtask

    task automatic log_mismatch(string what, logic [TASK_FIELD_BITS-1:0] want_v,
                                logic [TASK_FIELD_BITS-1:0] got_v);
        if (mismatch_count < 10)
            $display("%0t: mismatch on %s: expected %h, got %h", $time, what, want_v, got_v);
        mismatch_count++;
    endtask

    // Receiver back-pressure
    initial
    begin
        out_stall <= 1'b0;
        forever
        begin
            @(negedge clk);
            out_stall <= ($urandom_range(99) < rx_idle_pct);
        end
    end

    // Reply checker
    always @(posedge clk)
    begin
        if (rst_n === 1'b1 && out_valid === 1'b1 && out_stall === 1'b0)
        begin
            if (expected_replies.size() == 0)
                log_mismatch("unexpected reply owner_task", '0, owner_task);
            else
            begin
                oldest_reply = expected_replies.pop_front();
                if (ok !== oldest_reply.ok)
                    log_mismatch("ok", TASK_FIELD_BITS'(oldest_reply.ok),
                                 TASK_FIELD_BITS'(ok));
                if (owner_task !== oldest_reply.owner)
                    log_mismatch("owner_task", oldest_reply.owner, owner_task);
            end
        end
    end

    // Watchdog: too long with no request or reply moving
    initial
    begin
        int quiet_cycles;
        quiet_cycles = 0;
        while (quiet_cycles < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if ((in_valid === 1'b1 && in_stall === 1'b0) ||
                (out_valid === 1'b1 && out_stall === 1'b0))
                quiet_cycles = 0;
            else
                quiet_cycles++;
        end
        $display("%0t: watchdog expired", $time);
        $display("end of test: mismatches");
        $finish;
    end

    // Corner cases: extreme keys and ids, every action, duplicates, reuse
    task automatic test_directed();
        send_request(ACT_FIND, '0, '0);                    // empty table miss
        send_request(ACT_REGISTER, '0, '0);                // task id zero owns a slot
        send_request(ACT_FIND, '0, ID_ONES);
        send_request(ACT_REGISTER, KEY_ONES, ID_ONES);
        send_request(ACT_FIND, KEY_ONES, '0);
        send_request(ACT_REGISTER, '0, 16'h0005);          // duplicate key
        send_request(ACT_UNUSED, '0, '0);                  // unused action
        send_request(ACT_UNUSED, KEY_ONES, ID_ONES);
        send_request(ACT_FIND, '0, '0);
        send_request(ACT_TASK_END, KEY_ONES, ID_ONES);
        send_request(ACT_FIND, KEY_ONES, '0);
        send_request(ACT_TASK_END, '0, 16'h1234);          // task with no slots
        send_request(ACT_REGISTER, 64'h5555_5555_5555_5555, 16'h00FF);
        send_request(ACT_REGISTER, 64'hAAAA_AAAA_AAAA_AAAA, 16'h00FF);
        send_request(ACT_REGISTER, KEY_ONES, 16'hAAAA);    // takes a never-used slot
        send_request(ACT_FIND, 64'hAAAA_AAAA_AAAA_AAAA, '0);
        send_request(ACT_TASK_END, '0, 16'h00FF);
        send_request(ACT_FIND, 64'h5555_5555_5555_5555, '0);
        send_request(ACT_FIND, KEY_ONES, '0);
        send_request(ACT_TASK_END, '0, '0);
        send_request(ACT_FIND, '0, '0);
        send_request(ACT_TASK_END, '0, 16'hAAAA);
    endtask

    // Fill every slot, hit the full case, then free and refill
    task automatic test_table_full();
        logic [TASK_FIELD_BITS-1:0] fill_ids[FILL_OWNERS];
        int                         n;
        for (int i = 0; i < FILL_OWNERS; i++)
            fill_ids[i] = TASK_FIELD_BITS'($urandom);
        n = 0;
        // last register of the loop is the one refused for lack of room
        do
        begin
            send_request(ACT_REGISTER, {$urandom, 32'(n)}, fill_ids[n % FILL_OWNERS]);
            n++;
        end
        while (last_predicted.ok);
        send_request(ACT_REGISTER, {$urandom, 32'(n + 1)}, fill_ids[0]);
        send_request(ACT_FIND, KEY_ONES, '0);
        send_request(ACT_TASK_END, '0, fill_ids[1]);
        send_request(ACT_REGISTER, {$urandom, 32'(n + 2)}, fill_ids[2]);
        send_request(ACT_FIND, '0, '0);
        for (int i = 0; i < FILL_OWNERS; i++)
            send_request(ACT_TASK_END, {$urandom, $urandom}, fill_ids[i]);
    endtask

    // Random mix over small key and id pools so finds, duplicates and frees hit
    task automatic test_random_mix(int count);
        logic [KEY_FIELD_BITS-1:0]  key_pool[KEY_POOL_SIZE];
        logic [TASK_FIELD_BITS-1:0] id_pool[ID_POOL_SIZE];
        logic [KEY_FIELD_BITS-1:0]  key_r;
        logic [TASK_FIELD_BITS-1:0] id_r;
        int                         pick;
        for (int i = 0; i < KEY_POOL_SIZE; i++)
            key_pool[i] = {$urandom, $urandom};
        for (int i = 0; i < ID_POOL_SIZE; i++)
            id_pool[i] = TASK_FIELD_BITS'($urandom);
        for (int n = 0; n < count; n++)
        begin
            pick  = $urandom_range(99);
            key_r = key_pool[$urandom_range(KEY_POOL_SIZE - 1)];
            id_r  = id_pool[$urandom_range(ID_POOL_SIZE - 1)];
            if (pick < 35)
                send_request(ACT_REGISTER, key_r, id_r);
            else if (pick < 65)
            begin
                if ($urandom_range(4) == 0)
                    key_r = {$urandom, $urandom};
                send_request(ACT_FIND, key_r, TASK_FIELD_BITS'($urandom));
            end
            else if (pick < 78)
                send_request(ACT_TASK_END, {$urandom, $urandom}, id_r);
            else if (pick < 83)
                send_request(ACT_UNUSED, {$urandom, $urandom}, TASK_FIELD_BITS'($urandom));
            else
                send_request(2'($urandom_range(3)), {$urandom, $urandom},
                             TASK_FIELD_BITS'($urandom));
        end
    endtask

    // Sequence of tests
    initial
    begin
        rst_n          <= 1'b0;
        in_valid       <= 1'b0;
        action         <= ACT_FIND;
        name_key       <= '0;
        requester_task <= '0;
        mismatch_count = 0;
        set_idle(15, 57);
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_directed();
        test_random_mix(200);
        set_idle(57, 15);
        test_random_mix(190);
        set_idle(0, 0);
        test_table_full();
        test_random_mix(190);

        @(negedge clk);
        in_valid <= 1'b0;

        // drain, then give the block time to show any stray reply
        while (expected_replies.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (mismatch_count == 0 && expected_replies.size() == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule

[filelist.f]
rtl/ntr_pkg.sv
rtl/ntr_ram.sv
rtl/name_to_task_registry.sv
dv/tb_name_to_task_registry.sv
